@@ src/srp_pkg.sv @@
// Shared constants and types for the skyline rectangle packer.
package srp_pkg;

	localparam int MAX_COLUMNS = 2048;
	localparam int MAX_ROWS = 2048;

	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int DIM_W = 12;
	localparam int HGT_W = 12;
	localparam int POS_W = 11;
	localparam int AREA_W = 23;
	localparam int PROD_W = 2 * DIM_W;

	localparam int IN_TDATA_W = 24;
	localparam int OUT_FIELDS_W = 2 * POS_W + AREA_W;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_TUSER_W = 1;

	localparam logic [DIM_W-1:0] ATLAS_RESET = DIM_W'(2048);
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	typedef enum logic [0:0] {
		REG_ATLAS_WIDTH = 1'b0,
		REG_ATLAS_HEIGHT = 1'b1
	} reg_idx_t;

endpackage

@@ src/srp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module srp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/skyline_rect_packer.sv @@
// Skyline rectangle packer top level: request handling, column scans and skyline update.
//
// After reset the block clears the whole column store and takes no request until that is
// done. Configuration writes are taken at any time and apply from the next request on. A
// request that is zero-sized or larger than the atlas goes straight to the finish state,
// which loads its result. For any other request, one backward pass over the column store
// builds block-wise suffix maxima in a second memory. One forward pass combines them with
// running prefix maxima to get the highest column under every placement. If a placement
// was found, the covered columns are then written back one per cycle. Last, the result is
// loaded. The next request can be taken in the cycle after the result is loaded. A finished
// result waits in the output register while the next request is already being taken; a
// result that cannot be loaded because the previous one is still waiting holds the block
// until the output register frees up.
module skyline_rect_packer import srp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// rect_width [11:0], rect_height [23:12]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// pos_x [10:0], pos_y [21:11], area_used [44:22], zeros above
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// placed [0]
	output logic [OUT_TUSER_W-1:0] m_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  reg_idx_t               cfg_index,
	input  logic [DIM_W-1:0]       cfg_data
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_BACK   = 6'b000100,
		ST_FWD    = 6'b001000,
		ST_FILL   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	logic [DIM_W-1:0] atlas_w_q, atlas_h_q;
	logic [AREA_W-1:0] area_q;
	logic found_q;
	logic iss_on_q;
	logic vld_s1;
	logic m_tvalid_q;
	logic [COL_W-1:0] clr_addr_q;

	logic [DIM_W-1:0] w_q, h_q, cols_q, rows_q;
	logic [COL_W-1:0] wm1_q;
	logic [PROD_W-1:0] prod_q;
	logic [COL_W-1:0] iss_idx_q, cnt_q, c0_q;
	logic [COL_W-1:0] idx_s1, cnt_s1;
	logic first_s1, last_s1;
	logic [HGT_W-1:0] run_q;
	logic [COL_W-1:0] best_x_q;
	logic [HGT_W-1:0] best_y_q;
	logic [COL_W-1:0] fill_addr_q;
	logic [DIM_W-1:0] fill_left_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TUSER_W-1:0] m_tuser_q;

	logic [DIM_W-1:0] in_w, in_h, cols_c, rows_c;
	logic reject_c, accept_c, out_load_c;
	logic [HGT_W-1:0] hgt_rdata, sfx_rdata;
	logic hgt_we, sfx_we;
	logic [COL_W-1:0] hgt_waddr, sfx_raddr;
	logic [HGT_W-1:0] hgt_wdata;
	logic run_rst_c;
	logic [HGT_W-1:0] run_c, y_c, top_c;
	logic [COL_W-1:0] x_c, cnt_next_c;
	logic win_c, cand_c;
	logic [AREA_W+1:0] sum_c;
	logic [AREA_W-1:0] area_next_c;

	assign in_w = s_tdata[DIM_W-1:0];
	assign in_h = s_tdata[2*DIM_W-1:DIM_W];
	assign cols_c = (atlas_w_q < DIM_W'(MAX_COLUMNS)) ? atlas_w_q : DIM_W'(MAX_COLUMNS);
	assign rows_c = (atlas_h_q < DIM_W'(MAX_ROWS)) ? atlas_h_q : DIM_W'(MAX_ROWS);
	assign reject_c = (in_w == '0) || (in_h == '0) || (in_w > cols_c) || (in_h > rows_c);

	assign s_tready = (state_q == ST_IDLE);
	assign accept_c = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_load_c = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	assign cnt_next_c = (cnt_q == wm1_q) ? '0 : cnt_q + 1'b1;

	always_comb begin
		run_rst_c = (state_q == ST_BACK) ? (cnt_s1 == '0) : (first_s1 || cnt_s1 == '0);
		if (run_rst_c || hgt_rdata > run_q) begin
			run_c = hgt_rdata;
		end else begin
			run_c = run_q;
		end
		y_c = (sfx_rdata > run_c) ? sfx_rdata : run_c;
		x_c = idx_s1 - wm1_q;
		win_c = (idx_s1 >= wm1_q);
		cand_c = (state_q == ST_FWD) && vld_s1 && win_c &&
			((HGT_W + 1)'(y_c) + (HGT_W + 1)'(h_q) <= (HGT_W + 1)'(rows_q)) &&
			(!found_q || y_c < best_y_q);
		top_c = best_y_q + HGT_W'(h_q);
		sum_c = (AREA_W + 2)'(area_q) + (AREA_W + 2)'(prod_q);
		area_next_c = (sum_c > (AREA_W + 2)'(AREA_MAX)) ? AREA_MAX : sum_c[AREA_W-1:0];
	end

	always_comb begin
		hgt_we = 1'b0;
		hgt_waddr = fill_addr_q;
		hgt_wdata = top_c;
		case (state_q)
			ST_CLEAR: begin
				hgt_we = 1'b1;
				hgt_waddr = clr_addr_q;
				hgt_wdata = '0;
			end
			ST_FILL: begin
				hgt_we = 1'b1;
			end
			default: begin
				hgt_we = 1'b0;
			end
		endcase
	end

	assign sfx_we = (state_q == ST_BACK) && vld_s1;
	assign sfx_raddr = iss_idx_q - wm1_q;

	srp_ram #(
		.WIDTH (HGT_W),
		.DEPTH (MAX_COLUMNS)
	) u_heights (
		.clk   (clk),
		.we    (hgt_we),
		.waddr (hgt_waddr),
		.wdata (hgt_wdata),
		.raddr (iss_idx_q),
		.rdata (hgt_rdata)
	);

	srp_ram #(
		.WIDTH (HGT_W),
		.DEPTH (MAX_COLUMNS)
	) u_suffix (
		.clk   (clk),
		.we    (sfx_we),
		.waddr (idx_s1),
		.wdata (run_c),
		.raddr (sfx_raddr),
		.rdata (sfx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			atlas_w_q <= ATLAS_RESET;
			atlas_h_q <= ATLAS_RESET;
			area_q <= '0;
			found_q <= 1'b0;
			iss_on_q <= 1'b0;
			vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
			clr_addr_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATLAS_WIDTH: atlas_w_q <= cfg_data;
					REG_ATLAS_HEIGHT: atlas_h_q <= cfg_data;
					default: atlas_w_q <= atlas_w_q;
				endcase
			end
			vld_s1 <= iss_on_q && (state_q == ST_BACK || state_q == ST_FWD);
			if (out_load_c) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cand_c) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == COL_W'(MAX_COLUMNS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept_c) begin
						found_q <= 1'b0;
						if (reject_c) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_BACK;
							iss_on_q <= 1'b1;
						end
					end
				end
				ST_BACK: begin
					if (iss_on_q && iss_idx_q == '0) begin
						iss_on_q <= 1'b0;
					end
					if (vld_s1 && last_s1) begin
						state_q <= ST_FWD;
						iss_on_q <= 1'b1;
					end
				end
				ST_FWD: begin
					if (iss_on_q && iss_idx_q == COL_W'(cols_q - 1'b1)) begin
						iss_on_q <= 1'b0;
					end
					if (vld_s1 && last_s1) begin
						state_q <= (found_q || cand_c) ? ST_FILL : ST_FINISH;
					end
				end
				ST_FILL: begin
					if (fill_left_q == DIM_W'(1)) begin
						state_q <= ST_FINISH;
						area_q <= area_next_c;
					end
				end
				ST_FINISH: begin
					if (out_load_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (iss_on_q) begin
			idx_s1 <= iss_idx_q;
			cnt_s1 <= cnt_q;
			first_s1 <= (iss_idx_q == '0);
			cnt_q <= cnt_next_c;
		end
		if (vld_s1) begin
			run_q <= run_c;
		end
		if (cand_c) begin
			best_x_q <= x_c;
			best_y_q <= y_c;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept_c) begin
					w_q <= in_w;
					h_q <= in_h;
					wm1_q <= COL_W'(in_w - 1'b1);
					cols_q <= cols_c;
					rows_q <= rows_c;
					prod_q <= PROD_W'(in_w) * PROD_W'(in_h);
					iss_idx_q <= COL_W'(cols_c - 1'b1);
					cnt_q <= '0;
					best_x_q <= '0;
					best_y_q <= '0;
				end
			end
			ST_BACK: begin
				if (iss_on_q) begin
					last_s1 <= (iss_idx_q == '0);
					iss_idx_q <= iss_idx_q - 1'b1;
					if (iss_idx_q == '0) begin
						c0_q <= cnt_q;
					end
				end
				if (vld_s1 && last_s1) begin
					iss_idx_q <= '0;
					cnt_q <= wm1_q - c0_q;
				end
			end
			ST_FWD: begin
				if (iss_on_q) begin
					last_s1 <= (iss_idx_q == COL_W'(cols_q - 1'b1));
					iss_idx_q <= iss_idx_q + 1'b1;
				end
				fill_addr_q <= cand_c ? x_c : best_x_q;
				fill_left_q <= w_q;
			end
			ST_FILL: begin
				fill_addr_q <= fill_addr_q + 1'b1;
				fill_left_q <= fill_left_q - 1'b1;
			end
			ST_FINISH: begin
				if (out_load_c) begin
					m_tdata_q <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, area_q,
						POS_W'(best_y_q), POS_W'(best_x_q)};
					m_tuser_q <= OUT_TUSER_W'(found_q);
				end
			end
			default: begin
				fill_left_q <= fill_left_q;
			end
		endcase
	end

endmodule

@@ src/srp_checker.sv @@
// Port-level checks for the skyline rectangle packer, bound to the top level.
module srp_checker import srp_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input reg_idx_t               cfg_index,
	input logic [DIM_W-1:0]       cfg_data
);

	// A stalled result must hold its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A failed request reports the origin as its position.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[2*POS_W-1:0] == '0)
		else $error("failed request has nonzero position");

	// A placed rectangle always leaves a nonzero area total.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[OUT_FIELDS_W-1:2*POS_W] != '0)
		else $error("placed rectangle with zero area total");

	// Requests are handled one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in progress");

endmodule

bind skyline_rect_packer srp_checker u_srp_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the skyline rectangle packer.
module testbench;
	import srp_pkg::*;

	typedef struct packed {
		logic              placed;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [AREA_W-1:0] area;
	} placement_t;

	typedef struct {
		bit               is_cfg;
		reg_idx_t         idx;
		logic [DIM_W-1:0] a;
		logic [DIM_W-1:0] b;
		bit               typed;
		placement_t       want;
	} plan_step_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	reg_idx_t               cfg_index = REG_ATLAS_WIDTH;
	logic [DIM_W-1:0]       cfg_data = '0;

	logic [HGT_W-1:0]  sky [MAX_COLUMNS];
	logic [AREA_W-1:0] area_sum = '0;
	logic [DIM_W-1:0]  cols_reg = ATLAS_RESET;
	logic [DIM_W-1:0]  rows_reg = ATLAS_RESET;

	placement_t pending_places[$];
	plan_step_t plan[$];
	int  mismatch_count = 0;
	int  sender_gap_pct = 19;
	int  sink_stall_pct = 74;
	bit  cfg_open = 0;

	skyline_rect_packer uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("skyline_rect_packer regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Bottom-left placement over the current skyline; updates the skyline and the area total.
	function automatic placement_t place_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		int cols, rows, x, c, top, best_x, best_y;
		bit found;
		longint total;
		placement_t r;
		cols = (cols_reg < MAX_COLUMNS) ? cols_reg : MAX_COLUMNS;
		rows = (rows_reg < MAX_ROWS) ? rows_reg : MAX_ROWS;
		found = 0;
		best_x = 0;
		best_y = 0;
		if (w != 0 && h != 0 && w <= cols && h <= rows) begin
			for (x = 0; x + w <= cols; x++) begin
				top = 0;
				for (c = x; c < x + w && (!found || top < best_y); c++) begin
					if (sky[c] > top)
						top = sky[c];
				end
				if (top + h <= rows && (!found || top < best_y)) begin
					found = 1;
					best_x = x;
					best_y = top;
				end
			end
		end
		if (found) begin
			for (c = best_x; c < best_x + w; c++)
				sky[c] = HGT_W'(best_y + h);
			total = longint'(area_sum) + longint'(w) * longint'(h);
			area_sum = (total > longint'(AREA_MAX)) ? AREA_MAX : AREA_W'(total);
		end
		r.placed = found;
		r.pos_x = found ? POS_W'(best_x) : '0;
		r.pos_y = found ? POS_W'(best_y) : '0;
		r.area = area_sum;
		return r;
	endfunction

	function automatic plan_step_t cfg_row(input reg_idx_t idx, input int val);
		plan_step_t s;
		s = '{is_cfg: 1, idx: idx, a: DIM_W'(val), b: '0, typed: 0, want: '0};
		return s;
	endfunction

	function automatic plan_step_t req_row(input int w, input int h);
		plan_step_t s;
		s = '{is_cfg: 0, idx: REG_ATLAS_WIDTH, a: DIM_W'(w), b: DIM_W'(h), typed: 0, want: '0};
		return s;
	endfunction

	function automatic plan_step_t typed_row(input int w, input int h, input bit p,
			input int x, input int y, input int area);
		plan_step_t s;
		s = req_row(w, h);
		s.typed = 1;
		s.want = '{placed: p, pos_x: POS_W'(x), pos_y: POS_W'(y), area: AREA_W'(area)};
		return s;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_open = 1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_ATLAS_WIDTH)
			cols_reg = val;
		else
			rows_reg = val;
	endtask

	task automatic send_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h, input bit hold,
			input bit typed, input placement_t want);
		placement_t p;
		if (cfg_open) begin
			cfg_valid <= 1'b0;
			cfg_open = 0;
		end
		if (hold || $urandom_range(0, 99) < sender_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk);
			while (hold ? pending_places.size() != 0 : $urandom_range(0, 99) < sender_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {h, w};
		do @(posedge clk); while (!s_tready);
		p = place_rect(w, h);
		pending_places.push_back(typed ? want : p);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_places.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		placement_t got, want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got.placed = m_tuser[0];
			got.pos_x = m_tdata[POS_W-1:0];
			got.pos_y = m_tdata[2*POS_W-1:POS_W];
			got.area = m_tdata[2*POS_W+AREA_W-1:2*POS_W];
			if (pending_places.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: placed=%0d x=%0d y=%0d area=%0d",
						got.placed, got.pos_x, got.pos_y, got.area);
				mismatch_count++;
			end else begin
				want = pending_places.pop_front();
				if (got.placed !== want.placed || got.pos_x !== want.pos_x ||
						got.pos_y !== want.pos_y || got.area !== want.area) begin
					if (mismatch_count < 10)
						$display("mismatch: expected placed=%0d x=%0d y=%0d area=%0d, got placed=%0d x=%0d y=%0d area=%0d",
							want.placed, want.pos_x, want.pos_y, want.area,
							got.placed, got.pos_x, got.pos_y, got.area);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int phase_cols[6];
		int phase_rows[6];
		int ph, n, sel, wmax, hmax;
		logic [DIM_W-1:0] w, h;
		phase_cols = '{96, 200, 400, 700, 1100, 2048};
		phase_rows = '{40, 100, 250, 600, 1200, 2048};
		foreach (sky[i])
			sky[i] = '0;

		plan.push_back(typed_row(0, 5, 0, 0, 0, 0));
		plan.push_back(typed_row(5, 0, 0, 0, 0, 0));
		plan.push_back(typed_row(1, 2048, 1, 0, 0, 2048));
		plan.push_back(typed_row(2048, 1, 0, 0, 0, 2048));
		plan.push_back(typed_row(2047, 1, 1, 1, 0, 4095));
		plan.push_back(cfg_row(REG_ATLAS_WIDTH, 16));
		plan.push_back(cfg_row(REG_ATLAS_HEIGHT, 8));
		plan.push_back(typed_row(17, 1, 0, 0, 0, 4095));
		plan.push_back(typed_row(1, 9, 0, 0, 0, 4095));
		plan.push_back(typed_row(15, 7, 1, 1, 1, 4200));
		plan.push_back(typed_row(1, 1, 0, 0, 0, 4200));
		plan.push_back(cfg_row(REG_ATLAS_WIDTH, 20));
		plan.push_back(typed_row(4, 7, 1, 16, 1, 4228));
		plan.push_back(typed_row(1, 1, 0, 0, 0, 4228));
		plan.push_back(cfg_row(REG_ATLAS_WIDTH, 0));
		plan.push_back(typed_row(1, 1, 0, 0, 0, 4228));
		plan.push_back(cfg_row(REG_ATLAS_WIDTH, 4095));
		plan.push_back(cfg_row(REG_ATLAS_HEIGHT, 4095));
		plan.push_back(typed_row(2048, 2048, 0, 0, 0, 4228));
		plan.push_back(typed_row(1, 2047, 1, 20, 1, 6275));
		plan.push_back(cfg_row(REG_ATLAS_HEIGHT, 0));
		plan.push_back(typed_row(1, 1, 0, 0, 0, 6275));
		plan.push_back(cfg_row(REG_ATLAS_WIDTH, 1));
		plan.push_back(cfg_row(REG_ATLAS_HEIGHT, 1));
		plan.push_back(typed_row(1, 1, 0, 0, 0, 6275));
		plan.push_back(cfg_row(REG_ATLAS_WIDTH, 64));
		plan.push_back(cfg_row(REG_ATLAS_HEIGHT, 64));
		plan.push_back(req_row(3, 2));
		plan.push_back(req_row(64, 1));
		plan.push_back(req_row(5, 63));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (!cfg_open)
					settle();
				write_reg(plan[i].idx, plan[i].a);
			end else begin
				send_rect(plan[i].a, plan[i].b, 1'b0, plan[i].typed, plan[i].want);
			end
		end

		for (ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				sender_gap_pct = 74;
				sink_stall_pct = 19;
			end else if (ph == 4) begin
				sender_gap_pct = 0;
				sink_stall_pct = 0;
			end
			settle();
			write_reg(REG_ATLAS_WIDTH, DIM_W'(phase_cols[ph]));
			write_reg(REG_ATLAS_HEIGHT, DIM_W'(phase_rows[ph]));
			wmax = phase_cols[ph] / 4;
			hmax = phase_rows[ph] / 6 + 1;
			for (n = 0; n < 20; n++) begin
				sel = $urandom_range(0, 99);
				w = DIM_W'($urandom_range(0, 2048));
				h = DIM_W'($urandom_range(0, 2048));
				if (sel < 6) begin
					if ($urandom_range(0, 1))
						w = '0;
					else
						h = '0;
				end else if (sel < 14) begin
					// Any width and height from 0 to 2048, mostly oversized in the smaller phases.
				end else if (sel < 24) begin
					w = DIM_W'($urandom_range(1, phase_cols[ph]));
					h = DIM_W'($urandom_range(1, phase_rows[ph]));
				end else begin
					w = DIM_W'($urandom_range(1, wmax));
					h = DIM_W'($urandom_range(1, hmax));
				end
				send_rect(w, h, (ph == 0 && n == 5) || $urandom_range(0, 29) == 0, 1'b0, '0);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_places.size() == 0)
			$display("skyline_rect_packer regression: pass");
		else
			$display("skyline_rect_packer regression: fail");
		$finish;
	end

endmodule
